>>> hw/rtl/free_list_allocator_unit_assert.svh
// Assertion macros for the free list allocator.
`ifndef FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define FLA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("free list allocator check failed");

// next-cycle implication
`define FLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("free list allocator check failed");

`endif

>>> hw/rtl/fla_pkg.sv
// Shared constants, datapath commands and status for the free list allocator.
package fla_pkg;

  localparam int ARENA_UNITS = 4096;
  localparam int UNIT_BYTES  = 16;
  localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
  localparam int STORE_DEPTH = ARENA_UNITS + 1;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int WALK_LIMIT  = 4 * (ARENA_UNITS + 2);
  localparam int SW          = $clog2(WALK_LIMIT + 1);
  localparam int MGU_RESET   = 1024;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_A_INIT,
    OP_A_FIRST,
    OP_A_CHECK,
    OP_A_EXACT,
    OP_A_SPLIT1,
    OP_A_SPLIT2,
    OP_A_ADV,
    OP_A_REROVER,
    OP_GROW,
    OP_I_INIT,
    OP_I_ADV,
    OP_I_RD_BP,
    OP_I_RD_NX,
    OP_I_MERGE1,
    OP_I_MERGE2,
    OP_RES_ALLOC,
    OP_RES_FAIL,
    OP_RES_FREE
  } dp_op_e;

  typedef struct packed {
    logic is_free;
    logic free_ok;
    logic fit;
    logic exact;
    logic p_is_rover;
    logic steps_over;
    logic grow_ok;
    logic ins_hit;
    logic isteps_over;
  } dp_sts_t;

endpackage

>>> hw/rtl/fla_dp.sv
// Datapath: header stores, list pointers, arithmetic and result register.
module fla_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fla_pkg::dp_op_e         op_i,
  input  logic                    kind_i,
  input  logic [15:0]             request_bytes_i,
  input  logic [fla_pkg::AW-1:0]  free_addr_i,
  input  logic                    cfg_we_i,
  input  logic [fla_pkg::AW-1:0]  cfg_data_i,
  output fla_pkg::dp_sts_t        sts_o,
  output logic                    status_o,
  output logic [fla_pkg::AW-1:0]  addr_o
);

  localparam logic [fla_pkg::AW-1:0] MAX_IDX = fla_pkg::AW'(fla_pkg::ARENA_UNITS);

  logic [fla_pkg::AW-1:0] link_mem [fla_pkg::STORE_DEPTH];
  logic [fla_pkg::AW-1:0] size_mem [fla_pkg::STORE_DEPTH];

  logic [fla_pkg::AW-1:0] rd_link_q, rd_size_q;
  logic [fla_pkg::AW-1:0] rd_addr, wr_addr, wr_link, wr_size;
  logic                   wl_en, ws_en;

  logic                   kind_q;
  logic [fla_pkg::AW-1:0] need_q, bp_q, p_q, prev_q, nx_q, szp_q, szbp_q;
  logic [fla_pkg::SW-1:0] steps_q, isteps_q;
  logic [fla_pkg::AW-1:0] rover_q, brk_q, mgu_q;
  logic                   started_q;
  logic                   res_status_q;
  logic [fla_pkg::AW-1:0] res_addr_q;

  logic [16:0]            bytes_rnd;
  logic [fla_pkg::AW-1:0] need_calc, nu, split_sz, split_p, new_szbp, lbp;
  logic [fla_pkg::AW:0]   grow_end, bp_end, p_end;
  logic                   hit_nx, hit_p;

  assign bytes_rnd = ({1'b0, request_bytes_i} + 17'(fla_pkg::UNIT_BYTES - 1)) >>
                     fla_pkg::UNIT_SHIFT;
  assign need_calc = fla_pkg::AW'(bytes_rnd + 17'd1);
  assign nu        = (need_q > mgu_q) ? need_q : mgu_q;
  assign grow_end  = {1'b0, brk_q} + {1'b0, nu};
  assign split_sz  = szp_q - need_q;
  assign split_p   = p_q + split_sz;
  assign bp_end    = {1'b0, bp_q} + {1'b0, szbp_q};
  assign hit_nx    = (bp_end == {1'b0, nx_q});
  assign new_szbp  = hit_nx ? (szbp_q + rd_size_q) : szbp_q;
  assign lbp       = hit_nx ? rd_link_q : nx_q;
  assign p_end     = {1'b0, p_q} + {1'b0, szp_q};
  assign hit_p     = (p_end == {1'b0, bp_q});

  always_comb begin
    sts_o.is_free     = kind_q;
    sts_o.free_ok     = (bp_q != '0) && (bp_q < brk_q);
    sts_o.fit         = (szp_q >= need_q);
    sts_o.exact       = (szp_q == need_q);
    sts_o.p_is_rover  = (p_q == rover_q);
    sts_o.steps_over  = (steps_q >= fla_pkg::SW'(fla_pkg::WALK_LIMIT));
    sts_o.isteps_over = (isteps_q >= fla_pkg::SW'(fla_pkg::WALK_LIMIT));
    sts_o.grow_ok     = (grow_end <= (fla_pkg::AW + 1)'(fla_pkg::STORE_DEPTH));
    sts_o.ins_hit     = ((bp_q > p_q) && (bp_q < nx_q)) ||
                        ((p_q >= nx_q) && ((bp_q > p_q) || (bp_q < nx_q)));
  end

  always_comb begin
    rd_addr = rover_q;
    wl_en   = 1'b0;
    ws_en   = 1'b0;
    wr_addr = p_q;
    wr_link = nx_q;
    wr_size = need_q;
    case (op_i)
      fla_pkg::OP_START: begin
        wl_en   = !started_q;
        ws_en   = !started_q;
        wr_addr = '0;
        wr_link = '0;
        wr_size = '0;
      end
      fla_pkg::OP_A_FIRST:  rd_addr = rd_link_q;
      fla_pkg::OP_A_ADV:    rd_addr = nx_q;
      fla_pkg::OP_I_ADV:    rd_addr = nx_q;
      fla_pkg::OP_I_RD_BP:  rd_addr = bp_q;
      fla_pkg::OP_I_RD_NX:  rd_addr = nx_q;
      fla_pkg::OP_A_EXACT: begin
        wl_en   = 1'b1;
        wr_addr = prev_q;
        wr_link = nx_q;
      end
      fla_pkg::OP_A_SPLIT1: begin
        ws_en   = 1'b1;
        wr_size = split_sz;
      end
      fla_pkg::OP_A_SPLIT2: ws_en = 1'b1;
      fla_pkg::OP_GROW: begin
        ws_en   = 1'b1;
        wr_addr = brk_q;
        wr_size = nu;
      end
      fla_pkg::OP_I_MERGE1: begin
        wl_en   = 1'b1;
        ws_en   = 1'b1;
        wr_addr = bp_q;
        wr_link = lbp;
        wr_size = new_szbp;
      end
      fla_pkg::OP_I_MERGE2: begin
        wl_en   = 1'b1;
        ws_en   = hit_p;
        wr_link = hit_p ? nx_q : bp_q;
        wr_size = szp_q + szbp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wl_en && (wr_addr <= MAX_IDX)) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (ws_en && (wr_addr <= MAX_IDX)) begin
      size_mem[wr_addr] <= wr_size;
    end
    if (rd_addr <= MAX_IDX) begin
      rd_link_q <= link_mem[rd_addr];
      rd_size_q <= size_mem[rd_addr];
    end else begin
      rd_link_q <= '0;
      rd_size_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_q   <= '0;
      brk_q     <= fla_pkg::AW'(1);
      started_q <= 1'b0;
      mgu_q     <= fla_pkg::AW'(fla_pkg::MGU_RESET);
    end else begin
      if (cfg_we_i) begin
        mgu_q <= cfg_data_i;
      end
      case (op_i)
        fla_pkg::OP_START: begin
          if (!started_q) begin
            rover_q   <= '0;
            started_q <= 1'b1;
          end
        end
        fla_pkg::OP_A_EXACT:  rover_q <= prev_q;
        fla_pkg::OP_A_SPLIT1: rover_q <= prev_q;
        fla_pkg::OP_GROW:     brk_q   <= grow_end[fla_pkg::AW-1:0];
        fla_pkg::OP_I_MERGE2: rover_q <= p_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      fla_pkg::OP_LOAD: begin
        kind_q  <= kind_i;
        need_q  <= need_calc;
        bp_q    <= free_addr_i - fla_pkg::AW'(1);
        steps_q <= '0;
      end
      fla_pkg::OP_A_INIT: prev_q <= rover_q;
      fla_pkg::OP_A_FIRST: p_q <= rd_link_q;
      fla_pkg::OP_A_CHECK: begin
        szp_q <= rd_size_q;
        nx_q  <= rd_link_q;
      end
      fla_pkg::OP_A_SPLIT1: p_q <= split_p;
      fla_pkg::OP_A_ADV: begin
        steps_q <= steps_q + fla_pkg::SW'(1);
        prev_q  <= p_q;
        p_q     <= nx_q;
      end
      fla_pkg::OP_A_REROVER: p_q <= rover_q;
      fla_pkg::OP_GROW: bp_q <= brk_q;
      fla_pkg::OP_I_INIT: begin
        p_q      <= rover_q;
        isteps_q <= '0;
      end
      fla_pkg::OP_I_ADV: begin
        isteps_q <= isteps_q + fla_pkg::SW'(1);
        p_q      <= nx_q;
      end
      fla_pkg::OP_I_RD_NX: szbp_q <= rd_size_q;
      fla_pkg::OP_I_MERGE1: begin
        szbp_q <= new_szbp;
        nx_q   <= lbp;
      end
      fla_pkg::OP_RES_ALLOC: begin
        res_status_q <= 1'b0;
        res_addr_q   <= p_q + fla_pkg::AW'(1);
      end
      fla_pkg::OP_RES_FAIL: begin
        res_status_q <= 1'b1;
        res_addr_q   <= '0;
      end
      fla_pkg::OP_RES_FREE: begin
        res_status_q <= 1'b0;
        res_addr_q   <= '0;
      end
      default: ;
    endcase
    // insert walk latches the node it reads on the cycle after each read
    if (op_i == fla_pkg::OP_I_ADV || op_i == fla_pkg::OP_I_INIT) begin
      szp_q <= szp_q;
    end
  end

  assign status_o = res_status_q;
  assign addr_o   = res_addr_q;

endmodule

>>> hw/rtl/fla_ctrl.sv
// Controller: sequences allocate, grow and insert walks over the datapath.
module fla_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fla_pkg::dp_sts_t  sts_i,
  output fla_pkg::dp_op_e   op_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_FREE_CHK,
    S_A_INIT, S_A_FIRST, S_A_CHECK, S_A_DECIDE, S_A_EXACT, S_A_SPLIT1, S_A_SPLIT2,
    S_A_STEP, S_A_ADV, S_A_REROVER, S_A_RCHK,
    S_GROW_CHK, S_GROW,
    S_I_INIT, S_I_CHECK, S_I_DECIDE, S_I_ADV, S_I_RD_BP, S_I_RD_NX,
    S_I_MERGE1, S_I_MERGE2,
    S_RES_ALLOC, S_RES_FAIL, S_RES_FREE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_o        = fla_pkg::OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = fla_pkg::OP_LOAD;
          state_d = S_START;
        end
      end
      S_START: begin
        op_o    = fla_pkg::OP_START;
        state_d = sts_i.is_free ? S_FREE_CHK : S_A_INIT;
      end
      S_FREE_CHK:  state_d = sts_i.free_ok ? S_I_INIT : S_RES_FREE;
      S_A_INIT: begin
        op_o    = fla_pkg::OP_A_INIT;
        state_d = S_A_FIRST;
      end
      S_A_FIRST: begin
        op_o    = fla_pkg::OP_A_FIRST;
        state_d = S_A_CHECK;
      end
      S_A_CHECK: begin
        op_o    = fla_pkg::OP_A_CHECK;
        state_d = S_A_DECIDE;
      end
      S_A_DECIDE: begin
        if (sts_i.fit) begin
          state_d = sts_i.exact ? S_A_EXACT : S_A_SPLIT1;
        end else if (sts_i.p_is_rover) begin
          state_d = S_GROW_CHK;
        end else begin
          state_d = S_A_STEP;
        end
      end
      S_A_EXACT: begin
        op_o    = fla_pkg::OP_A_EXACT;
        state_d = S_RES_ALLOC;
      end
      S_A_SPLIT1: begin
        op_o    = fla_pkg::OP_A_SPLIT1;
        state_d = S_A_SPLIT2;
      end
      S_A_SPLIT2: begin
        op_o    = fla_pkg::OP_A_SPLIT2;
        state_d = S_RES_ALLOC;
      end
      S_A_STEP:    state_d = sts_i.steps_over ? S_RES_FAIL : S_A_ADV;
      S_A_ADV: begin
        op_o    = fla_pkg::OP_A_ADV;
        state_d = S_A_CHECK;
      end
      S_A_REROVER: begin
        op_o    = fla_pkg::OP_A_REROVER;
        state_d = S_A_RCHK;
      end
      S_A_RCHK: begin
        op_o    = fla_pkg::OP_A_CHECK;
        state_d = S_A_STEP;
      end
      S_GROW_CHK:  state_d = sts_i.grow_ok ? S_GROW : S_RES_FAIL;
      S_GROW: begin
        op_o    = fla_pkg::OP_GROW;
        state_d = S_I_INIT;
      end
      S_I_INIT: begin
        op_o    = fla_pkg::OP_I_INIT;
        state_d = S_I_CHECK;
      end
      S_I_CHECK: begin
        op_o    = fla_pkg::OP_A_CHECK;
        state_d = S_I_DECIDE;
      end
      S_I_DECIDE: begin
        if (sts_i.ins_hit) begin
          state_d = S_I_RD_BP;
        end else if (sts_i.isteps_over) begin
          state_d = sts_i.is_free ? S_RES_FREE : S_RES_FAIL;
        end else begin
          state_d = S_I_ADV;
        end
      end
      S_I_ADV: begin
        op_o    = fla_pkg::OP_I_ADV;
        state_d = S_I_CHECK;
      end
      S_I_RD_BP: begin
        op_o    = fla_pkg::OP_I_RD_BP;
        state_d = S_I_RD_NX;
      end
      S_I_RD_NX: begin
        op_o    = fla_pkg::OP_I_RD_NX;
        state_d = S_I_MERGE1;
      end
      S_I_MERGE1: begin
        op_o    = fla_pkg::OP_I_MERGE1;
        state_d = S_I_MERGE2;
      end
      S_I_MERGE2: begin
        op_o    = fla_pkg::OP_I_MERGE2;
        state_d = sts_i.is_free ? S_RES_FREE : S_A_REROVER;
      end
      S_RES_ALLOC: begin
        if (out_free) begin
          op_o        = fla_pkg::OP_RES_ALLOC;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RES_FAIL: begin
        if (out_free) begin
          op_o        = fla_pkg::OP_RES_FAIL;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RES_FREE: begin
        if (out_free) begin
          op_o        = fla_pkg::OP_RES_FREE;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hw/rtl/free_list_allocator_unit.sv
// Top level of the free list allocator: controller, datapath and assertions.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per request:
//   kind_i 0 allocates request_bytes_i bytes, kind_i 1 frees the block whose
//   payload unit is free_addr_i. Output channel (out_valid_o/out_ready_i)
//   returns one word per request: status_o (1 = no space) and addr_o.
//   The config channel writes min_grow_units_i at any handshake; write it
//   only while no request is in flight.
//   An allocate checks the first node visited and either unlinks it on an
//   exact fit or splits it, else walks on node by node. A growth extends the
//   break, links the new block in by an address-ordered insert walk and then
//   resumes the allocate walk. A free runs the same insert walk, or skips it
//   when out of range.
//   Throughput is one request at a time, set by the walk over the header
//   memories; the next word is taken only once the controller is idle again.
//   Reset: the list is empty, the break sits at unit 1, the growth chunk is
//   1024 units; the header memories are not cleared.
//   A stalled receiver holds the result word; a new request may be taken
//   meanwhile but its result waits for the output register to drain.
`include "free_list_allocator_unit_assert.svh"

module free_list_allocator_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [15:0]             request_bytes_i,
  input  logic [fla_pkg::AW-1:0]  free_addr_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    status_o,
  output logic [fla_pkg::AW-1:0]  addr_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [fla_pkg::AW-1:0]  min_grow_units_i
);

  fla_pkg::dp_op_e  op;
  fla_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .op_o        (op)
  );

  fla_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .kind_i          (kind_i),
    .request_bytes_i (request_bytes_i),
    .free_addr_i     (free_addr_i),
    .cfg_we_i        (cfg_valid_i),
    .cfg_data_i      (min_grow_units_i),
    .sts_o           (sts),
    .status_o        (status_o),
    .addr_o          (addr_o)
  );

  `FLA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `FLA_ASSERT_NOW(a_fail_addr_zero, out_valid_o && status_o, addr_o == '0)
  `FLA_ASSERT_NOW(a_result_after_work, $rose(out_valid_o), $past(!in_ready_o))

endmodule

>>> bench/free_list_allocator_unit_tb.sv
// Testbench for the free list allocator: random alloc/free traffic checked against a predictor.
module free_list_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 400000;
  localparam bit KIND_ALLOC = 1'b0;
  localparam bit KIND_FREE  = 1'b1;
  localparam bit ST_OK      = 1'b0;
  localparam bit ST_FULL    = 1'b1;

  typedef struct {
    bit                       status;
    bit [fla_pkg::AW-1:0]     addr;
  } alloc_result_t;

  class alloc_scoreboard;
    int unsigned link_mem[fla_pkg::STORE_DEPTH];
    int unsigned units_mem[fla_pkg::STORE_DEPTH];
    int unsigned rover;
    int unsigned brk;
    int unsigned grow_units;
    bit          started;
    alloc_result_t owed[$];

    function new();
      foreach (link_mem[i]) begin
        link_mem[i] = 0;
        units_mem[i] = 0;
      end
      rover = 0;
      brk = 1;
      grow_units = fla_pkg::MGU_RESET;
      started = 0;
    endfunction

    function int unsigned rd_link(int unsigned i);
      return (i < fla_pkg::STORE_DEPTH) ? link_mem[i] : 0;
    endfunction

    function int unsigned rd_units(int unsigned i);
      return (i < fla_pkg::STORE_DEPTH) ? units_mem[i] : 0;
    endfunction

    function void wr_link(int unsigned i, int unsigned v);
      if (i < fla_pkg::STORE_DEPTH) link_mem[i] = v;
    endfunction

    function void wr_units(int unsigned i, int unsigned v);
      if (i < fla_pkg::STORE_DEPTH) units_mem[i] = v;
    endfunction

    function void open_list();
      if (!started) begin
        link_mem[0] = 0;
        units_mem[0] = 0;
        rover = 0;
        started = 1;
      end
    endfunction

    function bit link_in(int unsigned bp);
      int unsigned p;
      int unsigned nx;
      int unsigned steps;
      p = rover;
      steps = 0;
      forever begin
        nx = rd_link(p);
        if (bp > p && bp < nx) break;
        if (p >= nx && (bp > p || bp < nx)) break;
        steps++;
        if (steps > fla_pkg::WALK_LIMIT) return 0;
        p = nx;
      end
      nx = rd_link(p);
      if (bp + rd_units(bp) == nx) begin
        wr_units(bp, rd_units(bp) + rd_units(nx));
        wr_link(bp, rd_link(nx));
      end else begin
        wr_link(bp, nx);
      end
      if (p + rd_units(p) == bp) begin
        wr_units(p, rd_units(p) + rd_units(bp));
        wr_link(p, rd_link(bp));
      end else begin
        wr_link(p, bp);
      end
      rover = p;
      return 1;
    endfunction

    function bit extend(int unsigned need);
      int unsigned nu;
      int unsigned up;
      nu = (need < grow_units) ? grow_units : need;
      up = brk;
      if (up + nu > fla_pkg::ARENA_UNITS + 1) return 0;
      brk = up + nu;
      wr_units(up, nu);
      return link_in(up);
    endfunction

    function int unsigned carve(int unsigned bytes);
      int unsigned need;
      int unsigned prev;
      int unsigned p;
      int unsigned sz;
      int unsigned steps;
      need = (bytes + fla_pkg::UNIT_BYTES - 1) / fla_pkg::UNIT_BYTES + 1;
      steps = 0;
      open_list();
      prev = rover;
      p = rd_link(prev);
      forever begin
        sz = rd_units(p);
        if (sz >= need) begin
          if (sz == need) begin
            wr_link(prev, rd_link(p));
          end else begin
            sz -= need;
            wr_units(p, sz);
            p += sz;
            wr_units(p, need);
          end
          rover = prev;
          return p + 1;
        end
        if (p == rover) begin
          if (!extend(need)) return 0;
          p = rover;
        end
        steps++;
        if (steps > fla_pkg::WALK_LIMIT) return 0;
        prev = p;
        p = rd_link(p);
      end
    endfunction

    // returns the predicted payload index (0 when none)
    function int unsigned note_request(bit kind, int unsigned bytes, int unsigned faddr);
      alloc_result_t r;
      int unsigned a;
      r.status = ST_OK;
      r.addr = '0;
      a = 0;
      if (kind == KIND_ALLOC) begin
        a = carve(bytes);
        if (a == 0) r.status = ST_FULL;
        else r.addr = a[fla_pkg::AW-1:0];
      end else begin
        open_list();
        if (faddr >= 2 && faddr - 1 < brk) void'(link_in(faddr - 1));
      end
      owed.push_back(r);
      return a;
    endfunction

    function string check_result(logic status, logic [fla_pkg::AW-1:0] addr);
      alloc_result_t r;
      if (owed.size() == 0) return $sformatf("unexpected word status=%0d addr=%0d", status, addr);
      r = owed.pop_front();
      if (r.status !== status || r.addr !== addr)
        return $sformatf("got status=%0d addr=%0d, want status=%0d addr=%0d",
                         status, addr, r.status, r.addr);
      return "";
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   kind_i;
  logic [15:0]            request_bytes_i;
  logic [fla_pkg::AW-1:0] free_addr_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   status_o;
  logic [fla_pkg::AW-1:0] addr_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [fla_pkg::AW-1:0] min_grow_units_i;

  free_list_allocator_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .request_bytes_i, .free_addr_i,
    .out_valid_o, .out_ready_i, .status_o, .addr_o, .cfg_valid_i, .cfg_ready_o,
    .min_grow_units_i
  );

  alloc_scoreboard sb;
  int errors;
  int idle_cycles;
  int unsigned live_blocks[$];
  int burst_left;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // receiver
  initial begin
    int mode;
    int left;
    out_ready_i = 0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        0: out_ready_i = 1;
        1: out_ready_i = $urandom_range(0, 1);
        2: out_ready_i = ($urandom_range(0, 7) == 0);
        default: out_ready_i = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && out_ready_i) begin
      msg = sb.check_result(status_o, addr_o);
      if (msg != "") report(msg);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_word(bit kind, int unsigned bytes, int unsigned faddr);
    int unsigned a;
    if (burst_left == 0) begin
      in_valid_i = 0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i = 1;
    kind_i = kind;
    request_bytes_i = bytes[15:0];
    free_addr_i = faddr[fla_pkg::AW-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    a = sb.note_request(kind, bytes, faddr);
    if (kind == KIND_ALLOC && a != 0) live_blocks.push_back(a);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_grow(int unsigned v);
    cfg_valid_i = 1;
    min_grow_units_i = v[fla_pkg::AW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.grow_units = v;
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic free_some();
    int idx;
    int unsigned a;
    if (live_blocks.size() == 0 || $urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 3))
        0: a = 0;
        1: a = 1;
        2: a = 8191;
        default: a = (sb.brk + 1 <= 8191) ? $urandom_range(sb.brk + 1, 8191) : 8191;
      endcase
    end else begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[idx];
      live_blocks.delete(idx);
    end
    send_word(KIND_FREE, $urandom_range(0, 65535), a);
  endtask

  task automatic random_phase(int n);
    int unsigned bytes;
    int sel;
    repeat (n) begin
      if ($urandom_range(0, 99) < 55) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) bytes = $urandom_range(0, 256);
        else if (sel < 95) bytes = $urandom_range(0, 2048);
        else bytes = $urandom_range(0, 65535);
        send_word(KIND_ALLOC, bytes, $urandom_range(0, 8191));
      end else begin
        free_some();
      end
    end
  endtask

  initial begin
    int unsigned grow_set[6];
    sb = new();
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    rst_ni = 0;
    in_valid_i = 0;
    kind_i = 0;
    request_bytes_i = '0;
    free_addr_i = '0;
    cfg_valid_i = 0;
    min_grow_units_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    repeat (2) @(negedge clk_i);

    // directed: first-use via free, out-of-range frees, arena full, splits
    send_word(KIND_FREE, 0, 1);
    send_word(KIND_ALLOC, 0, 0);
    send_word(KIND_ALLOC, 65535, 8191);
    send_word(KIND_ALLOC, 1, 0);
    send_word(KIND_ALLOC, 16, 0);
    send_word(KIND_ALLOC, 17, 0);
    send_word(KIND_FREE, 65535, 0);
    send_word(KIND_FREE, 0, 8191);
    send_word(KIND_FREE, 0, 4096);
    send_word(KIND_ALLOC, 65520, 0);
    send_word(KIND_ALLOC, 16000, 0);
    send_word(KIND_ALLOC, 100, 0);
    repeat (4) free_some();
    while (live_blocks.size() != 0) free_some();
    send_word(KIND_ALLOC, 65520, 0);
    send_word(KIND_ALLOC, 15, 0);
    while (live_blocks.size() != 0) free_some();
    drain();

    grow_set = '{1, 4096, 37, 1024, 0, 1};
    grow_set[4] = $urandom_range(1, 4096);
    foreach (grow_set[i]) begin
      write_grow(grow_set[i]);
      random_phase(205);
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
